[hdl/ypcs_pkg.sv]
// Shared types, constants and coefficients of the YIQ contrast stretch pipeline.
package ypcs_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // Pipeline split: front end (luma, chroma, segment numerator), back end (divide, recombine)
  localparam int unsigned FRONT_STAGES = 3;
  localparam int unsigned BACK_STAGES  = 5;
  localparam int unsigned NUM_STAGES   = FRONT_STAGES + BACK_STAGES;

  // Datapath widths
  localparam int unsigned LUMA_W      = 16;  // Y in Q8, unsigned before the offset
  localparam int unsigned YQ8_W       = 18;  // signed Q8 luminance and color differences
  localparam int unsigned CHROMA_W    = 18;  // I and Q in Q8
  localparam int unsigned NUM_W       = 28;  // rise * (Yb - x0)
  localparam int unsigned MAG_W       = 25;  // dividend magnitude
  localparam int unsigned RECIP_SHIFT = 25;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned PROD_W      = MAG_W + RECIP_W;
  localparam int unsigned QUO_W       = PROD_W - RECIP_SHIFT;
  localparam int unsigned CHK_W       = QUO_W + PIX_W;
  localparam int unsigned TERM_W      = 20;  // chroma contribution to one channel
  localparam int unsigned YM_W        = 27;  // mapped luminance and output channels, Q8

  // Q2.12 coefficients
  localparam int Y_R = 1225;
  localparam int Y_G = 2404;
  localparam int Y_B = 467;
  localparam int I_R = 2908;
  localparam int I_B = -1106;
  localparam int Q_R = 1966;
  localparam int Q_B = 1679;
  localparam int R_I = 3916;
  localparam int R_Q = 2540;
  localparam int G_I = -1114;
  localparam int G_Q = -2650;
  localparam int B_I = -4538;
  localparam int B_Q = 6984;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS = 3'd0,
    REG_LOW_IN     = 3'd1,
    REG_LOW_OUT    = 3'd2,
    REG_HIGH_IN    = 3'd3,
    REG_HIGH_OUT   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [PIX_W-1:0] brightness_offset;
    logic [PIX_W-1:0]        low_in;
    logic [PIX_W-1:0]        low_out;
    logic [PIX_W-1:0]        high_in;
    logic [PIX_W-1:0]        high_out;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    brightness_offset: 8'sd0,
    low_in:            8'd40,
    low_out:           8'd70,
    high_in:           8'd90,
    high_out:          8'd150
  };

  // Front end hands this to the back end
  typedef struct packed {
    logic signed [CHROMA_W-1:0] ci;
    logic signed [CHROMA_W-1:0] cq;
    logic signed [NUM_W-1:0]    num;
    logic [PIX_W-1:0]           t0;
    logic [PIX_W-1:0]           run;
  } front_t;

endpackage

[hdl/ypcs_if.sv]
// Handshake interfaces: pixel in, pixel out and configuration write.
interface ypcs_pix_in_if import ypcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] blue_in;

  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface ypcs_pix_out_if import ypcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_out;
  logic [PIX_W-1:0] green_out;
  logic [PIX_W-1:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

interface ypcs_cfg_if import ypcs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [PIX_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/yiq_piecewise_contrast_stretch.sv]
// Top level of the YIQ piecewise-linear contrast stretch.
//
// Usage:
//   pix_in_i  takes one RGB pixel per item; pix_out_o returns the stretched pixel.
//   cfg_i     writes a register by index: 0 brightness offset, 1 low_in,
//             2 low_out, 3 high_in, 4 high_out. Indexes past 4 are ignored.
//             Write only while no pixel is in flight; cfg_i.ready is always high.
// Pipeline: eight register stages (luma, differences and segment select,
//   chroma and numerator, reciprocal lookup, quotient multiply, correction,
//   mapped luma, recombine into the output register).
// Throughput: one pixel per clock while pix_out_o.ready is high; the 25x26
//   reciprocal multiply and the quotient check each own a stage, so no loop
//   holds a pixel back.
// Reset: all stages empty, registers back to offset 0, breakpoints
//   (40,70) and (90,150).
// Stall: when pix_out_o.ready is low the output holds, and each stage keeps
//   taking items until it is full, so bubbles close up before pix_in_i.ready
//   drops. Nothing is lost or repeated.
module yiq_piecewise_contrast_stretch import ypcs_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  ypcs_cfg_if.sink       cfg_i,
  ypcs_pix_in_if.sink    pix_in_i,
  ypcs_pix_out_if.source pix_out_o
);

  cfg_t                  cfg;
  logic [NUM_STAGES-1:0] en;
  logic                  in_ready;
  logic                  out_valid;
  front_t                front;

  ypcs_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  ypcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (pix_out_o.ready),
    .en_o        (en)
  );

  assign pix_in_i.ready  = in_ready;
  assign pix_out_o.valid = out_valid;

  ypcs_front u_front (
    .clk_i   (clk_i),
    .en_i    (en[FRONT_STAGES-1:0]),
    .cfg_i   (cfg),
    .red_i   (pix_in_i.red_in),
    .green_i (pix_in_i.green_in),
    .blue_i  (pix_in_i.blue_in),
    .front_o (front)
  );

  ypcs_back u_back (
    .clk_i   (clk_i),
    .en_i    (en[NUM_STAGES-1:FRONT_STAGES]),
    .front_i (front),
    .red_o   (pix_out_o.red_out),
    .green_o (pix_out_o.green_out),
    .blue_o  (pix_out_o.blue_out)
  );

endmodule

[hdl/ypcs_cfg.sv]
// Configuration register file.
module ypcs_cfg import ypcs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  ypcs_cfg_if.sink cfg_i,
  output cfg_t     cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_BRIGHTNESS: cfg_d.brightness_offset = $signed(cfg_i.data);
        REG_LOW_IN:     cfg_d.low_in            = cfg_i.data;
        REG_LOW_OUT:    cfg_d.low_out           = cfg_i.data;
        REG_HIGH_IN:    cfg_d.high_in           = cfg_i.data;
        REG_HIGH_OUT:   cfg_d.high_out          = cfg_i.data;
        default:        ;  // drop writes past the last register
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[hdl/ypcs_ctrl.sv]
// Valid bits and per-stage advance enables of the pipeline.
module ypcs_ctrl import ypcs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [NUM_STAGES-1:0] en_o
);

  logic [NUM_STAGES-1:0] vld_q, vld_d;
  logic [NUM_STAGES-1:0] en;

  // A stage advances when it is empty or the stage after it advances
  assign en[NUM_STAGES-1] = ~vld_q[NUM_STAGES-1] | out_ready_i;
  for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_en
    assign en[k] = ~vld_q[k] | en[k+1];
  end

  assign vld_d = (en & {vld_q[NUM_STAGES-2:0], in_valid_i}) | (~en & vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NUM_STAGES-1];
  assign en_o        = en;

endmodule

[hdl/ypcs_front.sv]
// Front end: luma, color differences, segment select, chroma and segment numerator.
module ypcs_front import ypcs_pkg::*; (
  input  logic                    clk_i,
  input  logic [FRONT_STAGES-1:0] en_i,
  input  cfg_t                    cfg_i,
  input  logic [PIX_W-1:0]        red_i,
  input  logic [PIX_W-1:0]        green_i,
  input  logic [PIX_W-1:0]        blue_i,
  output front_t                  front_o
);

  localparam int unsigned YSUM_W = LUMA_W + 4;

  // Stage 0: luminance
  logic [YSUM_W-1:0] ysum;
  logic [LUMA_W-1:0] y0_q;
  logic [PIX_W-1:0]  red0_q, blue0_q;

  assign ysum = YSUM_W'(Y_R) * YSUM_W'(red_i) + YSUM_W'(Y_G) * YSUM_W'(green_i)
              + YSUM_W'(Y_B) * YSUM_W'(blue_i);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      y0_q    <= ysum[YSUM_W-1:4];
      red0_q  <= red_i;
      blue0_q <= blue_i;
    end
  end

  // Stage 1: color differences, offset luminance, segment select
  logic signed [YQ8_W-1:0] y_s, dr, db, yb, l1_s, l2_s;
  logic [PIX_W-1:0]        x0, t0, run;
  logic signed [PIX_W:0]   rise;

  logic signed [YQ8_W-1:0] dr1_q, db1_q, yb1_q;
  logic [PIX_W-1:0]        x0_1_q, t0_1_q, run1_q;
  logic signed [PIX_W:0]   rise1_q;

  assign y_s  = $signed({2'b00, y0_q});
  assign dr   = $signed({2'b00, red0_q, 8'h00}) - y_s;
  assign db   = $signed({2'b00, blue0_q, 8'h00}) - y_s;
  assign yb   = y_s + $signed({{2{cfg_i.brightness_offset[PIX_W-1]}},
                               cfg_i.brightness_offset, 8'h00});
  assign l1_s = $signed({2'b00, cfg_i.low_in, 8'h00});
  assign l2_s = $signed({2'b00, cfg_i.high_in, 8'h00});

  always_comb begin
    priority if (yb <= l1_s) begin
      x0   = '0;
      t0   = '0;
      rise = $signed({1'b0, cfg_i.low_out});
      run  = cfg_i.low_in;
    end else if (yb <= l2_s) begin
      x0   = cfg_i.low_in;
      t0   = cfg_i.low_out;
      rise = $signed({1'b0, cfg_i.high_out}) - $signed({1'b0, cfg_i.low_out});
      run  = cfg_i.high_in - cfg_i.low_in;
    end else begin
      x0   = cfg_i.high_in;
      t0   = cfg_i.high_out;
      rise = 9'sd255 - $signed({1'b0, cfg_i.high_out});
      run  = 8'd255 - cfg_i.high_in;
    end
    // zero-width segment: flat at its starting output
    if (run == '0) begin
      rise = '0;
      run  = 8'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      dr1_q   <= dr;
      db1_q   <= db;
      yb1_q   <= yb;
      x0_1_q  <= x0;
      t0_1_q  <= t0;
      rise1_q <= rise;
      run1_q  <= run;
    end
  end

  // Stage 2: I, Q and the segment numerator
  logic signed [YQ8_W-1:0] rel;
  logic signed [NUM_W-1:0] num;
  logic signed [31:0]      ci_acc, cq_acc;
  front_t                  front_q;

  assign rel    = yb1_q - $signed({2'b00, x0_1_q, 8'h00});
  assign num    = NUM_W'(rise1_q) * NUM_W'(rel);
  assign ci_acc = 32'(dr1_q) * I_R + 32'(db1_q) * I_B;
  assign cq_acc = 32'(dr1_q) * Q_R + 32'(db1_q) * Q_B;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      front_q.ci  <= ci_acc[12 +: CHROMA_W];
      front_q.cq  <= cq_acc[12 +: CHROMA_W];
      front_q.num <= num;
      front_q.t0  <= t0_1_q;
      front_q.run <= run1_q;
    end
  end

  assign front_o = front_q;

endmodule

[hdl/ypcs_back.sv]
// Back end: floor division by reciprocal, mapped luminance, RGB recombine and clamp.
module ypcs_back import ypcs_pkg::*; (
  input  logic                   clk_i,
  input  logic [BACK_STAGES-1:0] en_i,
  input  front_t                 front_i,
  output logic [PIX_W-1:0]       red_o,
  output logic [PIX_W-1:0]       green_o,
  output logic [PIX_W-1:0]       blue_o
);

  localparam int unsigned DIV_TAB = 1 << PIX_W;

  // ceil(2^RECIP_SHIFT / d): estimate is the quotient or one above it
  logic [RECIP_W-1:0] recip_tab [DIV_TAB];
  assign recip_tab[0] = '0;
  for (genvar d = 1; d < DIV_TAB; d++) begin : g_recip
    localparam logic [RECIP_W-1:0] RC = RECIP_W'(((1 << RECIP_SHIFT) + d - 1) / d);
    assign recip_tab[d] = RC;
  end

  function automatic logic [PIX_W-1:0] clamp_ch(input logic signed [YM_W-1:0] v);
    logic [PIX_W-1:0] res;
    if (v[YM_W-1]) begin
      res = '0;
    end else if (v[YM_W-2:16] != '0) begin
      res = '1;
    end else begin
      res = v[15:8];
    end
    return res;
  endfunction

  // Stage 3: dividend magnitude, reciprocal, chroma terms.
  // floor(n/d) for n < 0 is -floor((-n + d - 1)/d), and -n - 1 is ~n.
  logic                     neg;
  logic [NUM_W-1:0]         mag_full;
  logic signed [31:0]       tr_acc, tg_acc, tb_acc;

  logic [MAG_W-1:0]         mag3_q;
  logic [RECIP_W-1:0]       recip3_q;
  logic                     neg3_q;
  logic [PIX_W-1:0]         run3_q, t0_3_q;
  logic signed [TERM_W-1:0] tr3_q, tg3_q, tb3_q;

  assign neg      = front_i.num[NUM_W-1];
  assign mag_full = neg ? (~front_i.num + NUM_W'(front_i.run)) : front_i.num;
  assign tr_acc   = 32'(front_i.ci) * R_I + 32'(front_i.cq) * R_Q;
  assign tg_acc   = 32'(front_i.ci) * G_I + 32'(front_i.cq) * G_Q;
  assign tb_acc   = 32'(front_i.ci) * B_I + 32'(front_i.cq) * B_Q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mag3_q   <= mag_full[MAG_W-1:0];
      recip3_q <= recip_tab[front_i.run];
      neg3_q   <= neg;
      run3_q   <= front_i.run;
      t0_3_q   <= front_i.t0;
      tr3_q    <= tr_acc[12 +: TERM_W];
      tg3_q    <= tg_acc[12 +: TERM_W];
      tb3_q    <= tb_acc[12 +: TERM_W];
    end
  end

  // Stage 4: quotient estimate
  logic [PROD_W-1:0]        prod;
  logic [QUO_W-1:0]         qe4_q;
  logic [MAG_W-1:0]         mag4_q;
  logic                     neg4_q;
  logic [PIX_W-1:0]         run4_q, t0_4_q;
  logic signed [TERM_W-1:0] tr4_q, tg4_q, tb4_q;

  assign prod = PROD_W'(mag3_q) * PROD_W'(recip3_q);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      qe4_q  <= prod[PROD_W-1:RECIP_SHIFT];
      mag4_q <= mag3_q;
      neg4_q <= neg3_q;
      run4_q <= run3_q;
      t0_4_q <= t0_3_q;
      tr4_q  <= tr3_q;
      tg4_q  <= tg3_q;
      tb4_q  <= tb3_q;
    end
  end

  // Stage 5: step the estimate back when it overshoots
  logic [CHK_W-1:0]         chk;
  logic [QUO_W-1:0]         q5_q;
  logic                     neg5_q;
  logic [PIX_W-1:0]         t0_5_q;
  logic signed [TERM_W-1:0] tr5_q, tg5_q, tb5_q;

  assign chk = CHK_W'(qe4_q) * CHK_W'(run4_q);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      q5_q   <= (chk > CHK_W'(mag4_q)) ? (qe4_q - QUO_W'(1)) : qe4_q;
      neg5_q <= neg4_q;
      t0_5_q <= t0_4_q;
      tr5_q  <= tr4_q;
      tg5_q  <= tg4_q;
      tb5_q  <= tb4_q;
    end
  end

  // Stage 6: mapped luminance
  logic signed [YM_W-1:0]   qs, ym;
  logic signed [YM_W-1:0]   ym6_q;
  logic signed [TERM_W-1:0] tr6_q, tg6_q, tb6_q;

  assign qs = $signed(YM_W'(q5_q));
  assign ym = $signed(YM_W'({t0_5_q, 8'h00})) + (neg5_q ? -qs : qs);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      ym6_q <= ym;
      tr6_q <= tr5_q;
      tg6_q <= tg5_q;
      tb6_q <= tb5_q;
    end
  end

  // Stage 7: recombine and clamp into the output register
  logic [PIX_W-1:0] red_q, green_q, blue_q;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      red_q   <= clamp_ch(ym6_q + YM_W'(tr6_q));
      green_q <= clamp_ch(ym6_q + YM_W'(tg6_q));
      blue_q  <= clamp_ch(ym6_q + YM_W'(tb6_q));
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule
